// ===== design/dls_pkg.sv =====
// Shared types, constants and the sigmoid table for the dense layer with sigmoid output.
`timescale 1ns / 1ps
package dls_pkg;

    // Default sizes of the layer.
    localparam int DEF_MAX_INPUTS  = 1024;
    localparam int DEF_MAX_OUTPUTS = 64;

    // Field and register widths.
    localparam int ROW_FIELD_W = 10;
    localparam int COL_FIELD_W = 6;
    localparam int WEIGHT_W    = 16;
    localparam int ACT_W       = 16;
    localparam int PROB_W      = 16;
    localparam int NODE_W      = 6;
    localparam int ACC_W       = 48;
    localparam int PROD_W      = ACT_W + 1 + WEIGHT_W;
    localparam int IN_CFG_W    = 11;
    localparam int OUT_CFG_W   = 7;
    localparam int CFG_DATA_W  = 11;

    // Register reset values.
    localparam logic [IN_CFG_W-1:0]  INPUTS_RESET  = IN_CFG_W'(784);
    localparam logic [OUT_CFG_W-1:0] OUTPUTS_RESET = OUT_CFG_W'(10);

    // Register indexes of the configuration port.
    localparam logic CFG_IDX_INPUTS  = 1'b0;
    localparam logic CFG_IDX_OUTPUTS = 1'b1;

    // Item kinds carried on tuser.
    localparam logic OP_WEIGHT = 1'b0;
    localparam logic OP_ACT    = 1'b1;

    // Sigmoid table: 1024 entries at 1/64 steps over [-8, 8).
    localparam int LUT_SIZE = 1024;
    localparam int LUT_IDX_W = 10;
    localparam int LUT_HALF = LUT_SIZE / 2;

    typedef logic [LUT_SIZE-1:0][PROB_W-1:0] sig_rom_t;

    // One item as it travels down the chain of cells.
    typedef struct packed {
        logic                   valid;
        logic                   op;
        logic                   last;
        logic [ROW_FIELD_W-1:0] row;
        logic [COL_FIELD_W-1:0] col;
        logic [WEIGHT_W-1:0]    wval;
        logic [ACT_W-1:0]       act;
    } dls_item_t;

    // Shift and subtract quotient, used only while the table is built.
    function automatic logic [63:0] table_quot(logic [63:0] num, logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Product of two Q0.62 values, kept in Q0.62.
    function automatic logic [63:0] table_mul_q62(logic [63:0] a, logic [63:0] b);
        logic [127:0] full;
        full = {64'd0, a} * {64'd0, b};
        return full[125:62];
    endfunction

    // Builds 65535 / (1 + exp(-x)) from a series for exp(-1/64) and repeated products.
    function automatic sig_rom_t build_sig_rom();
        sig_rom_t    rom;
        logic [63:0] one;
        logic [63:0] term;
        logic [63:0] r;
        logic [63:0] p;
        logic [63:0] pq;
        logic [63:0] den;
        logic [63:0] num;
        logic [63:0] v;
        rom  = '0;
        one  = 64'd1 << 62;
        term = one;
        r    = one;
        p    = one;
        for (int k = 1; k <= 12; k++) begin
            term = table_quot(term, 64'(64 * k));
            if ((k % 2) == 1) begin
                r = r - term;
            end else begin
                r = r + term;
            end
        end
        for (int d = 0; d <= LUT_HALF; d++) begin
            pq  = p >> 16;
            den = (64'd1 << 46) + pq;
            num = 64'd65535 << 46;
            v   = table_quot((num << 1) + den, den << 1);
            if (d < LUT_HALF) begin
                rom[LUT_HALF + d] = v[PROB_W-1:0];
            end
            if (d > 0) begin
                rom[LUT_HALF - d] = 16'hFFFF - v[PROB_W-1:0];
            end
            p = table_mul_q62(p, r);
        end
        return rom;
    endfunction

    localparam sig_rom_t SIG_ROM = build_sig_rom();

endpackage

// ===== design/dls_cell.sv =====
// One cell of the chain: the weights of one output node and its accumulator.
`timescale 1ns / 1ps
module dls_cell #(
    parameter int MAX_INPUTS = dls_pkg::DEF_MAX_INPUTS,
    parameter int CELL_IDX   = 0
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      acc_clr,
    input  dls_pkg::dls_item_t        item_i,
    output dls_pkg::dls_item_t        item_o,
    output logic [dls_pkg::ACC_W-1:0] acc_o
);
    import dls_pkg::*;

    localparam int ROW_W = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;

    logic [WEIGHT_W-1:0] weight_mem [MAX_INPUTS];

    dls_item_t                 item_reg;
    logic                      mac_en_reg;
    logic [ACT_W-1:0]          act_reg;
    logic signed [WEIGHT_W-1:0] w_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [PROD_W-1:0]  prod;
    logic                      wr_hit;
    logic                      act_hit;

    assign wr_hit  = item_i.valid && (item_i.op == OP_WEIGHT)
                     && (item_i.col == COL_FIELD_W'(CELL_IDX))
                     && (int'(item_i.row) < MAX_INPUTS);
    assign act_hit = item_i.valid && (item_i.op == OP_ACT);

    // Weight store of this node: written by weight items, read for each activation.
    always_ff @(posedge aclk) begin
        if (wr_hit) begin
            weight_mem[item_i.row[ROW_W-1:0]] <= item_i.wval;
        end
        if (act_hit) begin
            w_reg <= weight_mem[item_i.row[ROW_W-1:0]];
        end
        act_reg <= item_i.act;
    end

    assign prod = $signed({1'b0, act_reg}) * w_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_reg   <= '0;
            mac_en_reg <= 1'b0;
            acc_reg    <= '0;
        end else begin
            item_reg   <= item_i;
            mac_en_reg <= act_hit;
            if (acc_clr) begin
                acc_reg <= '0;
            end else if (mac_en_reg) begin
                acc_reg <= acc_reg + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
            end
        end
    end

    assign item_o = item_reg;
    assign acc_o  = acc_reg;

endmodule

// ===== design/dls_readout.sv =====
// Reads the accumulators in node order, clamps, looks up the sigmoid and drives the result channel.
`timescale 1ns / 1ps
module dls_readout #(
    parameter int MAX_OUTPUTS = dls_pkg::DEF_MAX_OUTPUTS,
    parameter int OCNT_W      = $clog2(MAX_OUTPUTS + 1)
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        start,
    input  logic [OCNT_W-1:0]                           m_eff,
    input  logic [MAX_OUTPUTS-1:0][dls_pkg::ACC_W-1:0]  acc_i,
    output logic                                        done,
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    output logic [23:0]                                 m_tdata,
    output logic                                        m_tlast
);
    import dls_pkg::*;

    localparam int OSEL_W = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;

    logic                      active_reg;
    logic [OCNT_W-1:0]         j_reg;
    logic                      s1_valid_reg;
    logic signed [ACC_W-1:0]   s1_sum_reg;
    logic [NODE_W-1:0]         s1_node_reg;
    logic                      s1_last_reg;
    logic                      s2_valid_reg;
    logic [LUT_IDX_W-1:0]      s2_idx_reg;
    logic [NODE_W-1:0]         s2_node_reg;
    logic                      s2_last_reg;
    logic                      out_valid_reg;
    logic [PROB_W-1:0]         out_prob_reg;
    logic [NODE_W-1:0]         out_node_reg;
    logic                      out_last_reg;

    logic                      adv;
    logic                      issue;
    logic                      issue_last;
    logic                      hi_sat;
    logic                      lo_sat;
    logic [LUT_IDX_W-1:0]      idx_next;

    assign adv        = !out_valid_reg || m_tready;
    assign issue      = active_reg && adv;
    assign issue_last = (j_reg == (m_eff - OCNT_W'(1)));
    assign done       = issue && issue_last;

    // Clamp to [-8, 8) in Q4.28, then take the top ten bits of the offset sum.
    assign hi_sat = !s1_sum_reg[ACC_W-1] && (s1_sum_reg[ACC_W-2:31] != '0);
    assign lo_sat = s1_sum_reg[ACC_W-1] && (s1_sum_reg[ACC_W-2:31] != '1);

    always_comb begin
        if (hi_sat) begin
            idx_next = '1;
        end else if (lo_sat) begin
            idx_next = '0;
        end else begin
            idx_next = {~s1_sum_reg[31], s1_sum_reg[30:22]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            j_reg         <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (start) begin
                active_reg <= 1'b1;
                j_reg      <= '0;
            end else if (issue) begin
                j_reg <= j_reg + OCNT_W'(1);
                if (issue_last) begin
                    active_reg <= 1'b0;
                end
            end
            if (adv) begin
                s1_valid_reg  <= issue;
                s2_valid_reg  <= s1_valid_reg;
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_sum_reg   <= acc_i[j_reg[OSEL_W-1:0]];
            s1_node_reg  <= NODE_W'(j_reg);
            s1_last_reg  <= issue_last;
            s2_idx_reg   <= idx_next;
            s2_node_reg  <= s1_node_reg;
            s2_last_reg  <= s1_last_reg;
            out_prob_reg <= SIG_ROM[s2_idx_reg];
            out_node_reg <= s2_node_reg;
            out_last_reg <= s2_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_prob_reg, out_node_reg};
    assign m_tlast  = out_last_reg;

endmodule

// ===== design/dense_layer_sigmoid.sv =====
// Top level of the fully connected layer with sigmoid output: input control, cell chain, readout.
`timescale 1ns / 1ps
//
// Usage:
// The input channel (s_) carries two kinds of item, chosen by s_tuser. A weight item
// (s_tuser = 0) stores one signed Q4.12 weight for an (input row, output node) pair. An
// activation item (s_tuser = 1) carries the next unsigned Q0.16 input of the current pass.
// Both kinds are taken one per cycle while s_tready is high. Each item walks down a chain
// of MAX_OUTPUTS cells, one cell per cycle; every cell owns the weights and accumulator of
// one output node, so weight writes and activations stay in order at every node.
// When the pass's last activation (inputs_in_use of them) has been taken, s_tready drops
// until the item has left the chain and every accumulator has been read. Results then leave
// one per cycle on the m_ channel while m_tready allows, node 0 first and m_tlast on the last
// node (outputs_in_use of them). The accumulators are cleared as the last one is read, and
// a new pass may start while results still drain.
// A stall on m_tready holds the readout pipeline; nothing is dropped.
// Reset (aresetn low at a clock edge) clears the accumulators, the activation count and
// all valid flags, and loads 784 inputs and 10 outputs. The weight store is not cleared:
// every weight a pass uses must be written first. Configuration is written on cfg_we.
//
module dense_layer_sigmoid #(
    parameter int MAX_INPUTS  = dls_pkg::DEF_MAX_INPUTS,
    parameter int MAX_OUTPUTS = dls_pkg::DEF_MAX_OUTPUTS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration write port.
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [dls_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // Input channel.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // s_tdata from bit 0: weight_row[9:0], weight_col[5:0], weight_value[15:0], activation[15:0]
    input  logic [47:0]                   s_tdata,
    // s_tuser: op (0 writes a weight, 1 delivers an activation)
    input  logic                          s_tuser,
    // Result channel.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // m_tdata from bit 0: node[5:0], probability[15:0], two zero bits
    output logic [23:0]                   m_tdata,
    output logic                          m_tlast
);
    import dls_pkg::*;

    localparam int ROW_W  = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
    localparam int OCNT_W = $clog2(MAX_OUTPUTS + 1);
    localparam int NCMP_W = IN_CFG_W + 1;

    // Pass control: take items, wait for the last activation to clear the chain, read out.
    typedef enum logic [2:0] {
        S_RUN   = 3'b001,
        S_DRAIN = 3'b010,
        S_READ  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [IN_CFG_W-1:0]  inputs_reg;
    logic [OUT_CFG_W-1:0] outputs_reg;
    logic [ROW_W-1:0]     count_reg;
    logic [ROW_W-1:0]     count_next;
    dls_item_t            head_reg;
    dls_item_t            head_next;

    logic [IN_CFG_W-1:0]  n_eff;
    logic [OCNT_W-1:0]    m_eff;
    logic                 accept;
    logic                 accept_act;
    logic                 pass_end;
    logic                 rd_start;
    logic                 rd_done;

    dls_item_t                          chain [MAX_OUTPUTS+1];
    logic [MAX_OUTPUTS-1:0][ACC_W-1:0]  acc_bus;

    // Counts out of range act as the nearest legal value.
    always_comb begin
        if (inputs_reg == '0) begin
            n_eff = IN_CFG_W'(1);
        end else if (int'(inputs_reg) > MAX_INPUTS) begin
            n_eff = IN_CFG_W'(MAX_INPUTS);
        end else begin
            n_eff = inputs_reg;
        end
        if (outputs_reg == '0) begin
            m_eff = OCNT_W'(1);
        end else if (int'(outputs_reg) > MAX_OUTPUTS) begin
            m_eff = OCNT_W'(MAX_OUTPUTS);
        end else begin
            m_eff = OCNT_W'(outputs_reg);
        end
    end

    assign s_tready   = (state_reg == S_RUN);
    assign accept     = s_tvalid && s_tready;
    assign accept_act = accept && (s_tuser == OP_ACT);
    // The pass ends on this activation once the count reaches the number in use;
    // a count already past a lowered limit also ends it.
    assign pass_end   = (NCMP_W'(count_reg) + NCMP_W'(1)) >= NCMP_W'(n_eff);

    always_comb begin
        head_next       = '0;
        head_next.valid = accept;
        head_next.op    = s_tuser;
        head_next.last  = accept_act && pass_end;
        head_next.row   = (s_tuser == OP_ACT) ? ROW_FIELD_W'(count_reg) : s_tdata[9:0];
        head_next.col   = s_tdata[15:10];
        head_next.wval  = s_tdata[31:16];
        head_next.act   = s_tdata[47:32];

        count_next = count_reg;
        if (accept_act) begin
            count_next = pass_end ? '0 : count_reg + ROW_W'(1);
        end
    end

    // The last activation shows at the chain's end as its final cell starts to add it.
    assign rd_start = (state_reg == S_DRAIN) && chain[MAX_OUTPUTS].valid
                      && chain[MAX_OUTPUTS].last;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_RUN: begin
                if (accept_act && pass_end) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (rd_start) begin
                    state_next = S_READ;
                end
            end
            S_READ: begin
                if (rd_done) begin
                    state_next = S_RUN;
                end
            end
            default: begin
                state_next = S_RUN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_RUN;
            inputs_reg  <= INPUTS_RESET;
            outputs_reg <= OUTPUTS_RESET;
            count_reg   <= '0;
            head_reg    <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            head_reg  <= head_next;
            if (cfg_we) begin
                if (cfg_index == CFG_IDX_INPUTS) begin
                    inputs_reg <= cfg_wdata[IN_CFG_W-1:0];
                end else begin
                    outputs_reg <= cfg_wdata[OUT_CFG_W-1:0];
                end
            end
        end
    end

    // The chain: each cell takes the item from its left neighbor every cycle.
    assign chain[0] = head_reg;

    for (genvar c = 0; c < MAX_OUTPUTS; c++) begin : g_cell
        dls_cell #(
            .MAX_INPUTS (MAX_INPUTS),
            .CELL_IDX   (c)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .acc_clr (rd_done),
            .item_i  (chain[c]),
            .item_o  (chain[c+1]),
            .acc_o   (acc_bus[c])
        );
    end

    // Readout clears the accumulators in the cycle it reads the last one.
    dls_readout #(
        .MAX_OUTPUTS (MAX_OUTPUTS),
        .OCNT_W      (OCNT_W)
    ) u_readout (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (rd_start),
        .m_eff    (m_eff),
        .acc_i    (acc_bus),
        .done     (rd_done),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
